### hdl/mqsa_pkg.sv
// shared types and codes for the multi-queue shared-array block
// item structs for both channels, command and status codes
// no dependencies
package mqsa_pkg;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_DELETE  = 2'd1;
  localparam logic [1:0] CMD_DISPLAY = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         queue_index;
    logic signed [31:0] value;
  } mqsa_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
  } mqsa_out_t;

endpackage

### hdl/mqsa_ram.sv
// single-port word memory holding every queue segment
// one address per cycle, written if wr_en and always read, read data registered
// depends on nothing outside this file
module mqsa_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     addr,
  input  logic signed [31:0] wr_data,
  output logic signed [31:0] rd_data_r
);

  logic signed [31:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
    rd_data_r <= mem_r[addr];
  end

endmodule

### hdl/multi_queue_shared_array_top.sv
// top level of the multi-queue shared-array block
// sequencer, queue pointers and output register; uses mqsa_pkg and mqsa_ram
// DEPTH words are split into num_queues equal non-circular segments
//
// Up to MAX_QUEUES FIFO queues share one DEPTH-word memory, each owning a segment of
// DEPTH / num_queues words. One item is worked at a time and in_stall is high until its
// last result has been taken. An out-of-range item goes from S_CHECK to S_OUT, others
// to S_ISSUE, which stores an insert unless full or moves the pointers; an insert or an
// empty error then goes to S_OUT, a delete or a display reads the registered memory
// through S_RD and S_RDATA, and a display returns to S_RD for each further word once
// the previous one is taken. The block takes a new item in the cycle after the final result is taken.
// Writing num_queues empties every queue; memory contents are kept.
module multi_queue_shared_array_top #(
  parameter int DEPTH      = 64,
  parameter int MAX_QUEUES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mqsa_pkg::mqsa_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mqsa_pkg::mqsa_out_t out_data,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data
);

  import mqsa_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

  // segment size for effective counts 1..8
  localparam int unsigned SEG_TBL [8] = '{DEPTH / 1, DEPTH / 2, DEPTH / 3, DEPTH / 4,
                                         DEPTH / 5, DEPTH / 6, DEPTH / 7, DEPTH / 8};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_RDATA = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         cmd_r;
  logic [2:0]         q_r;
  logic signed [31:0] val_r;
  logic [3:0]         eff_r;
  logic [CW-1:0]      seg_r;
  logic [AW-1:0]      start_r;
  logic [CW-1:0]      cursor_r;
  logic               last_r;
  logic [CW-1:0]      head_r [MAX_QUEUES];
  logic [CW-1:0]      fill_r [MAX_QUEUES];
  mqsa_out_t          out_r;

  logic [QW-1:0]      qi;
  logic [CW-1:0]      head_cur, fill_cur;
  logic [3:0]         cfg_eff;
  logic [2:0]         cfg_sel;
  logic [CW+2:0]      start_prod;
  logic [CW-1:0]      off;
  logic [CW:0]        addr_sum;
  logic [AW-1:0]      ram_addr;
  logic               ram_wr;
  logic signed [31:0] rd_data;
  logic               in_acc, out_acc;
  logic               q_bad, is_full, is_empty;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  assign qi       = q_r[QW-1:0];
  assign head_cur = head_r[qi];
  assign fill_cur = fill_r[qi];

  assign q_bad    = ({1'b0, q_r} >= eff_r);
  assign is_full  = (fill_cur >= seg_r);
  assign is_empty = (fill_cur == '0);

  // zero acts as one, anything above the limit as the limit
  always_comb begin
    priority if (cfg_wr_data == 4'd0) begin
      cfg_eff = 4'd1;
    end else if (cfg_wr_data > 4'(MAX_QUEUES)) begin
      cfg_eff = 4'(MAX_QUEUES);
    end else begin
      cfg_eff = cfg_wr_data;
    end
  end
  assign cfg_sel = 3'(cfg_eff - 4'd1);

  assign start_prod = (CW+3)'(seg_r) * (CW+3)'(q_r);

  // shared address adder: segment start plus rear, front or cursor offset
  assign off      = (state_r == S_ISSUE) ? fill_cur : cursor_r;
  assign addr_sum = (CW+1)'(start_r) + (CW+1)'(off);
  assign ram_addr = addr_sum[AW-1:0];
  assign ram_wr   = (state_r == S_ISSUE) && (cmd_r == CMD_INSERT) && !is_full;

  mqsa_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (ram_wr),
    .addr      (ram_addr),
    .wr_data   (val_r),
    .rd_data_r (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.command != CMD_NONE)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = q_bad ? S_OUT : S_ISSUE;
      end
      S_ISSUE: begin
        if (cmd_r == CMD_INSERT || is_empty) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          state_nxt = (cmd_r == CMD_DISPLAY && !out_r.last) ? S_RD : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      eff_r   <= 4'd1;
      seg_r   <= CW'(DEPTH);
      for (int i = 0; i < MAX_QUEUES; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        eff_r <= cfg_eff;
        seg_r <= CW'(SEG_TBL[cfg_sel]);
        for (int i = 0; i < MAX_QUEUES; i++) begin
          head_r[i] <= '0;
          fill_r[i] <= '0;
        end
      end else if (state_r == S_ISSUE) begin
        if (cmd_r == CMD_INSERT && !is_full) begin
          fill_r[qi] <= fill_cur + 1'b1;
        end else if (cmd_r == CMD_DELETE && !is_empty) begin
          // drained queue goes back to the start of its segment
          if ((CW+1)'(head_cur) + 1'b1 >= (CW+1)'(fill_cur)) begin
            head_r[qi] <= '0;
            fill_r[qi] <= '0;
          end else begin
            head_r[qi] <= head_cur + 1'b1;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_r <= in_data.command;
          q_r   <= in_data.queue_index;
          val_r <= in_data.value;
        end
      end
      S_CHECK: begin
        start_r <= start_prod[AW-1:0];
        if (q_bad) begin
          out_r <= '{status: STAT_RANGE, data: '0, last: 1'b1};
        end
      end
      S_ISSUE: begin
        cursor_r <= head_cur;
        if (cmd_r == CMD_INSERT) begin
          out_r <= '{status: (is_full ? STAT_FULL : STAT_OK), data: '0, last: 1'b1};
        end else if (is_empty) begin
          out_r <= '{status: STAT_EMPTY, data: '0, last: 1'b1};
        end
      end
      S_RD: begin
        last_r <= (cmd_r == CMD_DELETE) ||
                  ((CW+1)'(cursor_r) + 1'b1 == (CW+1)'(fill_cur));
      end
      S_RDATA: begin
        out_r <= '{status: STAT_OK, data: rd_data, last: last_r};
      end
      S_OUT: begin
        if (out_acc) begin
          cursor_r <= cursor_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### verif/multi_queue_shared_array_checker.sv
// result checker for the multi-queue shared-array block
// watches both channels and the count register, keeps a shadow of the queues and compares
// depends on mqsa_pkg
`timescale 1ns / 1ps
module multi_queue_shared_array_checker #(
  parameter int DEPTH      = 64,
  parameter int MAX_QUEUES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  mqsa_pkg::mqsa_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  mqsa_pkg::mqsa_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data,
  output int                  fail_count,
  output int                  results_seen,
  output int                  pending
);

  import mqsa_pkg::*;

  logic signed [31:0] shadow_mem [DEPTH];
  int                 head_ptr [MAX_QUEUES];
  int                 tail_ptr [MAX_QUEUES];
  logic [3:0]         queue_count;
  mqsa_out_t          awaited_results [$];
  int                 errors = 0;
  int                 checked = 0;

  assign fail_count   = errors;
  assign results_seen = checked;

  // zero and anything above the maximum fold back into range
  function automatic int live_queues();
    if (queue_count == 4'd0) return 1;
    if (queue_count > MAX_QUEUES) return MAX_QUEUES;
    return int'(queue_count);
  endfunction

  task automatic empty_every_queue();
    int seg;
    seg = DEPTH / live_queues();
    for (int q = 0; q < MAX_QUEUES; q++) begin
      head_ptr[q] = seg * q;
      tail_ptr[q] = seg * q - 1;
    end
  endtask

  task automatic await_result(input logic [1:0] st, input logic signed [31:0] d,
                              input logic lst);
    mqsa_out_t r;
    r.status = st;
    r.data   = d;
    r.last   = lst;
    awaited_results.push_back(r);
  endtask

  task automatic apply_command(input mqsa_in_t it);
    int q;
    int seg;
    int base;
    q    = int'(it.queue_index);
    seg  = DEPTH / live_queues();
    base = seg * q;
    if (it.command == CMD_NONE) return;
    if (q >= live_queues()) begin
      await_result(STAT_RANGE, '0, 1'b1);
      return;
    end
    if (it.command == CMD_INSERT) begin
      if (tail_ptr[q] >= base + seg - 1) begin
        await_result(STAT_FULL, '0, 1'b1);
      end else begin
        tail_ptr[q]++;
        shadow_mem[tail_ptr[q]] = it.value;
        await_result(STAT_OK, '0, 1'b1);
      end
    end else if (tail_ptr[q] == base - 1) begin
      await_result(STAT_EMPTY, '0, 1'b1);
    end else if (it.command == CMD_DELETE) begin
      await_result(STAT_OK, shadow_mem[head_ptr[q]], 1'b1);
      head_ptr[q]++;
      // a drained queue starts again at the bottom of its segment
      if (head_ptr[q] > tail_ptr[q]) begin
        head_ptr[q] = base;
        tail_ptr[q] = base - 1;
      end
    end else begin
      for (int j = head_ptr[q]; j <= tail_ptr[q]; j++)
        await_result(STAT_OK, shadow_mem[j], j == tail_ptr[q]);
    end
  endtask

  always @(posedge clk) begin
    mqsa_out_t want;
    if (!rst_n) begin
      foreach (shadow_mem[i]) shadow_mem[i] = '0;
      queue_count = 4'd1;
      empty_every_queue();
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d data %0d last %0d",
                   $time, out_data.status, out_data.data, out_data.last);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, want.status, out_data.status);
            errors++;
          end
          if (out_data.data !== want.data) begin
            $display("%0t: data mismatch, expected %0d got %0d",
                     $time, want.data, out_data.data);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $display("%0t: last mismatch, expected %0d got %0d",
                     $time, want.last, out_data.last);
            errors++;
          end
        end
      end
      if (cfg_wr_en) begin
        queue_count = cfg_wr_data;
        empty_every_queue();
      end
      if (in_valid && !in_stall) apply_command(in_data);
    end
    pending <= awaited_results.size();
  end

endmodule

### verif/multi_queue_shared_array_top_tb.sv
// testbench top for the multi-queue shared-array block
// drives items, the count register and output stalls; checking lives in
// multi_queue_shared_array_checker, types come from mqsa_pkg
`timescale 1ns / 1ps
module multi_queue_shared_array_top_tb;
  import mqsa_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  mqsa_in_t   in_data     = '0;
  logic       out_stall   = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic [3:0] cfg_wr_data = 4'd0;
  logic       in_stall;
  logic       out_valid;
  mqsa_out_t  out_data;

  int         send_idle_pct = 24;
  int         recv_idle_pct = 77;
  logic [3:0] cur_count     = 4'd1;
  int         items_sent    = 0;
  int         quiet_cycles  = 0;
  int         fail_total;
  int         results_seen;
  int         pending_results;

  logic [31:0] corner_vals [8] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0,
                                   32'h1, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001};

  multi_queue_shared_array_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  multi_queue_shared_array_checker queue_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_total),
    .results_seen (results_seen),
    .pending      (pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // no handshake of any kind for too long means the block has hung
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("FAIL multi_queue_shared_array_top");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [2:0] qi,
                           input logic [31:0] val);
    in_data  <= '{command: cmd, queue_index: qi, value: val};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // wait for the last result, then let any result-less item finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_count(input logic [3:0] n);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_count = n;
  endtask

  function automatic logic [2:0] pick_queue();
    int live;
    live = (cur_count == 4'd0) ? 1 : ((cur_count > 4'd8) ? 8 : int'(cur_count));
    if ($urandom_range(99) < 85) return 3'($urandom_range(live - 1));
    return 3'($urandom_range(7));
  endfunction

  // filling stretches push queues towards full, draining ones towards empty
  function automatic logic [1:0] pick_command(input bit filling);
    int r;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 86) return CMD_INSERT;
      if (r < 92) return CMD_DELETE;
      if (r < 97) return CMD_DISPLAY;
      return CMD_NONE;
    end
    if (r < 20) return CMD_INSERT;
    if (r < 70) return CMD_DELETE;
    if (r < 96) return CMD_DISPLAY;
    return CMD_NONE;
  endfunction

  task automatic run_phase(input logic [3:0] n, input int items, input int burst);
    bit filling;
    write_count(n);
    filling = 1'b1;
    for (int k = 0; k < items; k++) begin
      if (k > 0 && k % burst == 0) filling = !filling;
      send_item(pick_command(filling), pick_queue(), $urandom());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_count(4'd8);
    send_item(CMD_DISPLAY, 3'd0, 32'h0);
    send_item(CMD_DELETE, 3'd0, 32'h0);
    foreach (corner_vals[i]) send_item(CMD_INSERT, 3'd7, corner_vals[i]);
    send_item(CMD_INSERT, 3'd7, 32'h1234_5678);
    send_item(CMD_DISPLAY, 3'd7, 32'h0);
    send_item(CMD_DELETE, 3'd7, 32'hFFFF_FFFF);
    send_item(CMD_NONE, 3'd5, 32'hDEAD_BEEF);
    send_item(CMD_INSERT, 3'd0, 32'd42);
    send_item(CMD_DELETE, 3'd0, 32'h0);
    send_item(CMD_DELETE, 3'd0, 32'h0);
    // an oversized count behaves as the maximum and the write empties queue 7
    write_count(4'd15);
    send_item(CMD_DISPLAY, 3'd7, 32'h0);
    // a count of zero behaves as one queue
    write_count(4'd0);
    send_item(CMD_INSERT, 3'd1, 32'h0);
    send_item(CMD_DISPLAY, 3'd7, 32'h0);
    send_item(CMD_DELETE, 3'd4, 32'h0);
    send_item(CMD_INSERT, 3'd0, 32'hFFFF_FFFB);
    send_item(CMD_DISPLAY, 3'd0, 32'h0);

    run_phase(4'd8, 40, 12);
    run_phase(4'd3, 35, 10);
    send_idle_pct = 77;
    recv_idle_pct = 24;
    run_phase(4'd1, 75, 72);
    run_phase(4'd5, 35, 9);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(4'd15, 35, 10);
    run_phase(4'd2, 40, 16);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (20) @(posedge clk);

    $display("%0d items sent over queue counts 0, 1, 2, 3, 5, 8 and 15", items_sent);
    $display("%0d results checked under sender, receiver and no idling", results_seen);
    if (fail_total == 0 && pending_results == 0) begin
      $display("PASS multi_queue_shared_array_top");
    end else begin
      $display("FAIL multi_queue_shared_array_top");
    end
    $finish;
  end

endmodule
